@@ design/lwe_cma_pkg.sv @@
// Shared types and constants for the LWE coefficient modular ALU.
`default_nettype none
package lwe_cma_pkg;

	localparam int unsigned DataW      = 32;
	localparam int unsigned ModW       = 33;
	localparam int unsigned WideW      = 64;
	localparam int unsigned DivBits    = 2;
	localparam int unsigned DivStages  = WideW / DivBits;
	localparam int unsigned ApbAddrW   = 4;
	localparam int unsigned ApbDataW   = 64;

	localparam logic [ModW-1:0] ModMin     = 33'd2;
	localparam logic [ModW-1:0] ModMax     = 33'h1_0000_0000;
	localparam logic [ModW-1:0] QModReset  = 33'h1_0000_0000;
	localparam logic [ModW-1:0] QTgtReset  = 33'd1024;

	typedef enum logic [2:0] {
		KIND_ADD    = 3'd0,
		KIND_SUB    = 3'd1,
		KIND_NEG    = 3'd2,
		KIND_SMUL   = 3'd3,
		KIND_LADD   = 3'd4,
		KIND_LSMUL  = 3'd5,
		KIND_SWITCH = 3'd6
	} kind_t;

	// register index, taken from paddr[3]
	typedef enum logic {
		REG_Q_MODULUS = 1'b0,
		REG_Q_TARGET  = 1'b1
	} reg_idx_t;

	// side information that travels alongside the divider
	typedef struct packed {
		logic [2:0]       kind;
		logic             neg;
		logic             last;
		logic [WideW-1:0] lazy;
	} side_t;

	function automatic logic [ModW-1:0] clamp_mod(input logic [ModW-1:0] v);
		logic [ModW-1:0] r;
		if (v < ModMin) begin
			r = ModMin;
		end else if (v > ModMax) begin
			r = ModMax;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/lwe_cma_if.sv @@
// Stream interfaces for coefficient words and result words.
`default_nettype none
interface lwe_cma_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [31:0]        elem_a;
	logic [31:0]        operand_b;
	logic signed [31:0] scalar;
	logic               is_last;

	modport source (output valid, kind, elem_a, operand_b, scalar, is_last, input ready);
	modport sink   (input valid, kind, elem_a, operand_b, scalar, is_last, output ready);
endinterface

interface lwe_cma_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] result;
	logic               last;

	modport source (output valid, result, last, input ready);
	modport sink   (input valid, result, last, output ready);
endinterface
`default_nettype wire

@@ design/lwe_cma_front.sv @@
// Operand preparation and multiplier stages.
`default_nettype none
module lwe_cma_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [2:0]                  kind,
	input  wire logic [lwe_cma_pkg::DataW-1:0] elem_a,
	input  wire logic [lwe_cma_pkg::DataW-1:0] operand_b,
	input  wire logic [lwe_cma_pkg::DataW-1:0] scalar,
	input  wire logic                        is_last,
	input  wire logic [lwe_cma_pkg::ModW-1:0] qt,
	output logic                             out_valid,
	output logic [lwe_cma_pkg::WideW-1:0]    dividend,
	output lwe_cma_pkg::side_t               side
);
	import lwe_cma_pkg::*;

	logic             sneg;
	logic [DataW-1:0] smag;
	logic [ModW-1:0]  sum, diff, x_c, m_c;
	logic             neg_c;

	logic             vld_s1;
	logic [2:0]       kind_s1;
	logic [DataW-1:0] a_s1;
	logic [ModW-1:0]  m_s1, x_s1;
	logic             neg_s1, last_s1;

	logic [WideW-1:0] prod;
	logic [WideW-1:0] div_c, lazy_c;

	logic             vld_s2;
	logic [WideW-1:0] dividend_s2;
	side_t            side_s2;

	always_comb begin
		sneg = scalar[DataW-1];
		smag = sneg ? (~scalar + 32'd1) : scalar;
		sum  = {1'b0, elem_a} + {1'b0, operand_b};
		diff = (elem_a >= operand_b) ? {1'b0, elem_a - operand_b}
			: {1'b0, operand_b - elem_a};
		x_c   = sum;
		m_c   = '0;
		neg_c = 1'b0;
		case (kind)
			KIND_ADD, KIND_LADD: begin
				x_c = sum;
			end
			KIND_SUB: begin
				x_c   = diff;
				neg_c = elem_a < operand_b;
			end
			KIND_NEG: begin
				x_c   = {1'b0, elem_a};
				neg_c = 1'b1;
			end
			KIND_SMUL, KIND_LSMUL: begin
				m_c   = {1'b0, smag};
				neg_c = sneg;
			end
			KIND_SWITCH: begin
				m_c = qt;
			end
			default: begin
				x_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			a_s1    <= elem_a;
			m_s1    <= m_c;
			x_s1    <= x_c;
			neg_s1  <= neg_c;
			last_s1 <= is_last;
		end
	end

	// product stays below 2^64 for every legal multiplier
	always_comb begin
		prod  = {32'b0, a_s1} * {31'b0, m_s1};
		div_c = ((kind_s1 == KIND_SMUL) || (kind_s1 == KIND_SWITCH))
			? prod : {31'b0, x_s1};
		lazy_c = (kind_s1 == KIND_LSMUL) ? prod : {31'b0, x_s1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dividend_s2  <= div_c;
			side_s2.kind <= kind_s1;
			side_s2.neg  <= neg_s1;
			side_s2.last <= last_s1;
			side_s2.lazy <= lazy_c;
		end
	end

	assign out_valid = vld_s2;
	assign dividend  = dividend_s2;
	assign side      = side_s2;
endmodule
`default_nettype wire

@@ design/lwe_cma_div.sv @@
// Pipelined restoring divider, two quotient bits per stage.
`default_nettype none
module lwe_cma_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [lwe_cma_pkg::WideW-1:0] dividend,
	input  wire lwe_cma_pkg::side_t           side_in,
	input  wire logic [lwe_cma_pkg::ModW-1:0] q,
	output logic                              out_valid,
	output logic [lwe_cma_pkg::WideW-1:0]     quotient,
	output logic [lwe_cma_pkg::DataW-1:0]     remainder,
	output lwe_cma_pkg::side_t                side_out
);
	import lwe_cma_pkg::*;

	// dq holds the unconsumed dividend bits on top, quotient bits shift in below
	logic [DivStages-1:0] vld_s;
	logic [DataW-1:0]     rem_s  [DivStages];
	logic [WideW-1:0]     dq_s   [DivStages];
	side_t                side_s [DivStages];

	logic [DataW-1:0]     rem_n  [DivStages];
	logic [WideW-1:0]     dq_n   [DivStages];

	genvar gi;
	generate
		for (gi = 0; gi < DivStages; gi++) begin : g_stage
			always_comb begin
				logic [DataW-1:0] r;
				logic [WideW-1:0] d;
				logic [ModW-1:0]  t;
				logic             ge;
				if (gi == 0) begin
					r = '0;
					d = dividend;
				end else begin
					r = rem_s[(gi == 0) ? 0 : gi-1];
					d = dq_s[(gi == 0) ? 0 : gi-1];
				end
				for (int k = 0; k < DivBits; k++) begin
					t  = {r, d[WideW-1]};
					ge = t >= q;
					r  = ge ? DataW'(t - q) : t[DataW-1:0];
					d  = {d[WideW-2:0], ge};
				end
				rem_n[gi] = r;
				dq_n[gi]  = d;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[gi]  <= rem_n[gi];
					dq_s[gi]   <= dq_n[gi];
					side_s[gi] <= (gi == 0) ? side_in : side_s[(gi == 0) ? 0 : gi-1];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DivStages-2:0], in_valid};
		end
	end

	assign out_valid = vld_s[DivStages-1];
	assign quotient  = dq_s[DivStages-1];
	assign remainder = rem_s[DivStages-1];
	assign side_out  = side_s[DivStages-1];
endmodule
`default_nettype wire

@@ design/lwe_cma_back.sv @@
// Residue sign fix, switch rounding, result select and output register.
`default_nettype none
module lwe_cma_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [lwe_cma_pkg::WideW-1:0] quotient,
	input  wire logic [lwe_cma_pkg::DataW-1:0] remainder,
	input  wire lwe_cma_pkg::side_t           side,
	input  wire logic [lwe_cma_pkg::ModW-1:0] q,
	output logic                              out_valid,
	output logic [lwe_cma_pkg::WideW-1:0]     result,
	output logic                              last
);
	import lwe_cma_pkg::*;

	logic [WideW-1:0] res_c;
	logic             round_up;
	logic             valid_q;
	logic [WideW-1:0] result_q;
	logic             last_q;

	always_comb begin
		round_up = {remainder, 1'b0} >= q;
		case (side.kind)
			KIND_ADD, KIND_SUB, KIND_NEG, KIND_SMUL: begin
				if (side.neg && (remainder != '0)) begin
					res_c = {31'b0, q - {1'b0, remainder}};
				end else begin
					res_c = {32'b0, remainder};
				end
			end
			KIND_LADD: begin
				res_c = side.lazy;
			end
			KIND_LSMUL: begin
				res_c = side.neg ? (~side.lazy + 64'd1) : side.lazy;
			end
			KIND_SWITCH: begin
				res_c = quotient + {63'b0, round_up};
			end
			default: begin
				res_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res_c;
			last_q   <= side.last;
		end
	end

	assign out_valid = valid_q;
	assign result    = result_q;
	assign last      = last_q;
endmodule
`default_nettype wire

@@ design/lwe_coefficient_mod_alu.sv @@
// Top level of the LWE coefficient modular ALU.
// Takes one coefficient word per cycle and returns one result word per word, in order,
// through two operand/multiplier stages, 32 divider stages (a 64-by-33-bit restoring
// division, two quotient bits per stage) and the output register. The whole pipeline
// advances whenever the output register is empty or being taken, so the rate is one word
// per cycle while the sink keeps ready high. q_modulus sits at address 0 and q_target at
// address 8; both are clamped to [2, 2^32] before use and should only be written while
// the pipeline is empty.
`default_nettype none
module lwe_coefficient_mod_alu (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lwe_cma_pkg::ApbAddrW-1:0] paddr,
	input  wire logic [lwe_cma_pkg::ApbDataW-1:0] pwdata,
	output logic [lwe_cma_pkg::ApbDataW-1:0]     prdata,
	output logic                                 pready,
	lwe_cma_in_if.sink                           coef,
	lwe_cma_out_if.source                        res
);
	import lwe_cma_pkg::*;

	logic [ModW-1:0]  q_mod_q, q_tgt_q, q_eff, qt_eff;
	logic             en;
	logic             f_valid, d_valid;
	logic [WideW-1:0] f_dividend, d_quot, b_result;
	logic [DataW-1:0] d_rem;
	side_t            f_side, d_side;
	logic             b_valid, b_last;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_mod_q <= QModReset;
			q_tgt_q <= QTgtReset;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[3]))
				REG_Q_MODULUS: q_mod_q <= pwdata[ModW-1:0];
				REG_Q_TARGET:  q_tgt_q <= pwdata[ModW-1:0];
				default:       q_mod_q <= q_mod_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3]))
			REG_Q_MODULUS: prdata = {31'b0, q_mod_q};
			REG_Q_TARGET:  prdata = {31'b0, q_tgt_q};
			default:       prdata = '0;
		endcase
	end

	assign q_eff  = clamp_mod(q_mod_q);
	assign qt_eff = clamp_mod(q_tgt_q);

	assign en         = !b_valid || res.ready;
	assign coef.ready = en;

	lwe_cma_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (coef.valid),
		.kind      (coef.kind),
		.elem_a    (coef.elem_a),
		.operand_b (coef.operand_b),
		.scalar    (coef.scalar),
		.is_last   (coef.is_last),
		.qt        (qt_eff),
		.out_valid (f_valid),
		.dividend  (f_dividend),
		.side      (f_side)
	);

	lwe_cma_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.dividend  (f_dividend),
		.side_in   (f_side),
		.q         (q_eff),
		.out_valid (d_valid),
		.quotient  (d_quot),
		.remainder (d_rem),
		.side_out  (d_side)
	);

	lwe_cma_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d_valid),
		.quotient  (d_quot),
		.remainder (d_rem),
		.side      (d_side),
		.q         (q_eff),
		.out_valid (b_valid),
		.result    (b_result),
		.last      (b_last)
	);

	assign res.valid  = b_valid;
	assign res.result = b_result;
	assign res.last   = b_last;
endmodule
`default_nettype wire

@@ design/lwe_cma_chk.sv @@
// Port-level checks for the LWE coefficient modular ALU, bound to the top level.
`default_nettype none
module lwe_cma_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic pready
);
	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// input side only stalls while a result word is held back
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result word offered during reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port inserted wait state");
endmodule

bind lwe_coefficient_mod_alu lwe_cma_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (coef.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.pready    (pready)
);
`default_nettype wire
